### rtl/sspp_pkg.sv
// Shared types, codes and defaults for the shared stack placement policy unit.
package sspp_pkg;

  // Default sizing of the stack table and the saturating counters
  localparam int MaxStacksDef  = 16;
  localparam int CountWidthDef = 16;
  localparam int MinStacks     = 4;

  // Reset values of the configuration registers
  localparam logic [4:0]  INIT_STACKS_RST  = 5'd4;
  localparam logic [15:0] AGING_PERIOD_RST = 16'd100;
  localparam logic [15:0] SPAWN_THRESH_RST = 16'd20;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_STACKS  = 2'd0;
  localparam logic [1:0] CFG_AGING_PERIOD = 2'd1;
  localparam logic [1:0] CFG_SPAWN_THRESH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PLACE  = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef struct packed {
    req_e        req_type;
    logic [3:0]  stack_index;
    logic [15:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [3:0] chosen_stack;
    logic       stack_created;
    logic [4:0] stack_count;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_DRAIN,
    ST_ADD_WR,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_TICK_CHK,
    ST_AGE_SWEEP,
    ST_AGE_DRAIN,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic acc_rd;
    logic add_wr;
    logic acc_wr;
    logic tick_upd;
    logic set_oob;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ptr_zero;
    logic idx_oob;
    logic tick_wrap;
  } dp_sts_t;

endpackage

### rtl/sspp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sspp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sspp_ctrl.sv
// Request sequencer of the shared stack placement policy unit.
module sspp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sspp_pkg::req_e    req_type_i,
  input  sspp_pkg::dp_sts_t sts_i,
  output sspp_pkg::dp_cmd_t cmd_o,
  output logic              busy
);
  import sspp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_ADD:    state_d = ST_ADD_SCAN;
            REQ_REMOVE: state_d = ST_ACC_RD;
            REQ_PLACE:  state_d = ST_ACC_RD;
            REQ_TICK:   state_d = ST_TICK_CHK;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_SCAN:  if (sts_i.ptr_zero) state_d = ST_ADD_DRAIN;
      ST_ADD_DRAIN: state_d = ST_ADD_WR;
      ST_ADD_WR:    state_d = ST_FINISH;
      ST_ACC_RD:    state_d = sts_i.idx_oob ? ST_FINISH : ST_ACC_WR;
      ST_ACC_WR:    state_d = ST_FINISH;
      ST_TICK_CHK:  state_d = sts_i.tick_wrap ? ST_AGE_SWEEP : ST_FINISH;
      ST_AGE_SWEEP: if (sts_i.ptr_zero) state_d = ST_AGE_DRAIN;
      ST_AGE_DRAIN: state_d = ST_FINISH;
      ST_FINISH:    state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:      cmd_o.load     = start;
      ST_ADD_SCAN:  cmd_o.scan_rd  = 1'b1;
      ST_ADD_WR:    cmd_o.add_wr   = 1'b1;
      ST_ACC_RD: begin
        cmd_o.set_oob = sts_i.idx_oob;
        cmd_o.acc_rd  = !sts_i.idx_oob;
      end
      ST_ACC_WR:    cmd_o.acc_wr   = 1'b1;
      ST_TICK_CHK:  cmd_o.tick_upd = 1'b1;
      ST_AGE_SWEEP: cmd_o.scan_rd  = 1'b1;
      ST_FINISH:    cmd_o.finish   = 1'b1;
      default:      cmd_o          = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### rtl/sspp_dp.sv
// Datapath of the shared stack placement policy unit: config, stack table, scan and update.
module sspp_dp #(
  parameter int MaxStacks  = sspp_pkg::MaxStacksDef,
  parameter int CountWidth = sspp_pkg::CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [15:0]       cfg_data_i,
  input  sspp_pkg::req_t    req_i,
  input  sspp_pkg::dp_cmd_t cmd_i,
  output sspp_pkg::dp_sts_t sts_o,
  output sspp_pkg::rsp_t    result_o,
  output logic              done_o
);
  import sspp_pkg::*;

  localparam int SW   = (CountWidth < 16) ? CountWidth : 16;  // counter storage width
  localparam int WW   = SW + 1;                               // weight width
  localparam int EntW = 3 * SW + 16;
  localparam int IW   = $clog2(MaxStacks);
  localparam int CNW  = $clog2(MaxStacks + 1);
  localparam int CmpW = 17;
  localparam int SumW = 8;

  // configuration
  logic [4:0]  init_q;
  logic [15:0] period_q, thresh_q;

  // request context
  req_t           req_q;
  logic [CNW-1:0] cnt_q, extra_q;
  logic [15:0]    tick_q;
  logic [IW-1:0]  ptr_q, cmp_idx_q, best_q, chosen_q;
  logic           pend_q, rd_vld_q, created_q;
  logic [WW-1:0]  min_q;
  logic [EntW-1:0] best_ent_q;
  logic [1:0]     status_q;
  logic [MaxStacks-1:0] vld_q;
  rsp_t           res_q;
  logic           done_q;

  // stack table access
  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr, idx_w, target;
  logic [EntW-1:0] ram_wdata, ram_rdata, rd_ent, age_ent, add_ent, acc_ent, base_ent;

  logic [SW-1:0]  rd_old, rd_cur, rd_res, rd_avg, base_res, add_res;
  logic [15:0]    rd_act;
  logic [SW:0]    rate_sum;
  logic [WW-1:0]  wt;
  logic [SumW-1:0] base_n, sum_n;
  logic [CNW-1:0] cnt_now;
  logic [16:0]    tick_inc;
  logic           do_cmp, do_age, spawn, add_sat;
  logic [1:0]     acc_sts;

  // stacks in use from the configured base and the opened extras
  always_comb begin
    base_n = SumW'(init_q);
    if (base_n < SumW'(MinStacks)) base_n = SumW'(MinStacks);
    if (base_n > SumW'(MaxStacks)) base_n = SumW'(MaxStacks);
    sum_n = base_n + SumW'(extra_q);
    if (sum_n > SumW'(MaxStacks)) sum_n = SumW'(MaxStacks);
    cnt_now = CNW'(sum_n);
  end

  assign rd_ent   = rd_vld_q ? ram_rdata : '0;
  assign rd_old   = rd_ent[SW-1:0];
  assign rd_cur   = rd_ent[2*SW-1:SW];
  assign rd_res   = rd_ent[3*SW-1:2*SW];
  assign rd_act   = rd_ent[EntW-1:3*SW];
  assign rate_sum = {1'b0, rd_old} + {1'b0, rd_cur};
  assign rd_avg   = rate_sum[SW:1];
  assign wt       = WW'(rd_avg) + WW'(rd_res);

  assign do_cmp = pend_q && (req_q.req_type == REQ_ADD);
  assign do_age = pend_q && (req_q.req_type == REQ_TICK);

  assign age_ent = {rd_act, rd_res, {SW{1'b0}}, rd_avg};

  // add: open a stack when the lightest one is still too heavy
  assign spawn    = (CmpW'(min_q) > CmpW'(thresh_q)) && (cnt_q < CNW'(MaxStacks));
  assign target   = spawn ? IW'(cnt_q) : best_q;
  assign base_ent = spawn ? '0 : best_ent_q;
  assign base_res = base_ent[3*SW-1:2*SW];
  assign add_sat  = (base_res == {SW{1'b1}});
  assign add_res  = add_sat ? base_res : base_res + SW'(1);
  assign add_ent  = {base_ent[EntW-1:3*SW], add_res, base_ent[2*SW-1:0]};

  // remove and place on the addressed stack
  assign idx_w = IW'(req_q.stack_index);

  always_comb begin
    acc_ent = rd_ent;
    acc_sts = ST_OK;
    if (req_q.req_type == REQ_REMOVE) begin
      if (rd_act == req_q.thread_id) acc_ent[EntW-1:3*SW] = '0;
      if (rd_res == '0) begin
        acc_sts = ST_SATURATED;
      end else begin
        acc_ent[3*SW-1:2*SW] = rd_res - SW'(1);
      end
    end else if (rd_act != req_q.thread_id) begin
      if (rd_act != '0) begin
        if (rd_cur == {SW{1'b1}}) begin
          acc_sts = ST_SATURATED;
        end else begin
          acc_ent[2*SW-1:SW] = rd_cur + SW'(1);
        end
      end
      acc_ent[EntW-1:3*SW] = req_q.thread_id;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q;
    ram_wdata = age_ent;
    if (do_age) ram_we = 1'b1;
    if (cmd_i.add_wr) begin
      ram_we    = 1'b1;
      ram_waddr = target;
      ram_wdata = add_ent;
    end
    if (cmd_i.acc_wr) begin
      ram_we    = 1'b1;
      ram_waddr = idx_w;
      ram_wdata = acc_ent;
    end
  end

  assign ram_raddr = cmd_i.scan_rd ? ptr_q : idx_w;
  assign tick_inc  = {1'b0, tick_q} + 17'd1;

  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.idx_oob   = (SumW'(req_q.stack_index) >= SumW'(cnt_q));
  assign sts_o.tick_wrap = (tick_inc > {1'b0, period_q});

  sspp_ram #(
    .Width (EntW),
    .Depth (MaxStacks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= INIT_STACKS_RST;
      period_q <= AGING_PERIOD_RST;
      thresh_q <= SPAWN_THRESH_RST;
      extra_q  <= '0;
      tick_q   <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_INIT_STACKS:  init_q   <= cfg_data_i[4:0];
          CFG_AGING_PERIOD: period_q <= cfg_data_i;
          CFG_SPAWN_THRESH: thresh_q <= cfg_data_i;
          default:          init_q   <= init_q;
        endcase
      end
      if (cmd_i.add_wr && spawn) extra_q <= extra_q + CNW'(1);
      if (cmd_i.tick_upd) tick_q <= sts_o.tick_wrap ? '0 : tick_inc[15:0];
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
      rd_vld_q <= vld_q[ram_raddr];
      pend_q   <= cmd_i.scan_rd;
      done_q   <= cmd_i.finish;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_i;
      cnt_q     <= cnt_now;
      ptr_q     <= IW'(cnt_now - CNW'(1));
      min_q     <= '1;
      status_q  <= ST_OK;
      chosen_q  <= '0;
      created_q <= 1'b0;
    end
    if (cmd_i.scan_rd) begin
      ptr_q     <= ptr_q - IW'(1);
      cmp_idx_q <= ptr_q;
    end
    // strict compare while scanning downward keeps the newest stack on a tie
    if (do_cmp && (wt < min_q)) begin
      min_q      <= wt;
      best_q     <= cmp_idx_q;
      best_ent_q <= rd_ent;
    end
    if (cmd_i.add_wr) begin
      chosen_q  <= target;
      created_q <= spawn;
      if (add_sat) status_q <= ST_SATURATED;
    end
    if (cmd_i.acc_wr) status_q <= acc_sts;
    if (cmd_i.set_oob) status_q <= ST_BAD_INDEX;
    if (cmd_i.finish) begin
      res_q.chosen_stack  <= 4'(chosen_q);
      res_q.stack_created <= created_q;
      res_q.stack_count   <= 5'(cnt_now);
      res_q.status        <= status_q;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### rtl/shared_stack_placement_policy_unit.sv
// Top level of the shared stack placement policy unit.
// One item at a time: an item is taken when start is high and busy is low, and its
// result shows on result_o for the single cycle that done_o is high; the receiver
// must take it then. Timing is set by the one-read-port stack table that add and
// aging walk entry by entry: an add, and a tick that ends an aging period, read every
// stack in use; remove and place read and write the addressed entry, and skip the
// write for an index not in use. busy drops in the cycle done_o rises.
module shared_stack_placement_policy_unit #(
  parameter int MaxStacks  = sspp_pkg::MaxStacksDef,
  parameter int CountWidth = sspp_pkg::CountWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sspp_pkg::req_t req_i,
  output logic           done_o,
  output sspp_pkg::rsp_t result_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_addr_i,
  input  logic [15:0]    cfg_data_i
);
  import sspp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sspp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  sspp_dp #(
    .MaxStacks  (MaxStacks),
    .CountWidth (CountWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (result_o),
    .done_o     (done_o)
  );

endmodule

### sim/shared_stack_placement_policy_unit_test.sv
// Self-checking testbench for the shared stack placement policy unit.
module shared_stack_placement_policy_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sspp_pkg::*;

  localparam int          NumStacks    = MaxStacksDef;
  localparam int unsigned CountMax     = 32'h0000_FFFF;
  localparam int          SettleCycles = NumStacks + 8;
  localparam longint      CycleLimit   = 4_000_000;
  localparam int          RandomItems  = 1350;
  localparam int          RandomPhases = 6;
  localparam int          BurstItems   = 32;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  req_t        req_i      = '0;
  logic        done_o;
  rsp_t        result_o;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  shared_stack_placement_policy_unit u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted configuration and stack table
  logic [4:0]  cfg_init   = INIT_STACKS_RST;
  logic [15:0] cfg_period = AGING_PERIOD_RST;
  logic [15:0] cfg_thresh = SPAWN_THRESH_RST;

  logic [15:0] aged_swaps [NumStacks] = '{default: '0};
  logic [15:0] cur_swaps  [NumStacks] = '{default: '0};
  logic [15:0] thread_cnt [NumStacks] = '{default: '0};
  logic [15:0] active_tid [NumStacks] = '{default: '0};
  logic [4:0]  opened_stacks = '0;
  logic [15:0] tick_cnt      = '0;

  rsp_t   expected_rsp_q [$];
  rsp_t   want;
  int     mismatches = 0;
  longint cycle_cnt  = 0;
  bit     no_idle    = 1'b0;
  int     burst_left = 0;

  function automatic int unsigned stacks_in_use();
    int unsigned n;
    n = cfg_init;
    if (n < MinStacks) n = MinStacks;
    if (n > NumStacks) n = NumStacks;
    n += opened_stacks;
    return (n > NumStacks) ? NumStacks : n;
  endfunction

  function automatic int unsigned stack_weight(int unsigned i);
    return (32'(aged_swaps[i]) + 32'(cur_swaps[i])) / 2 + 32'(thread_cnt[i]);
  endfunction

  function automatic rsp_t predict_policy(input req_t item);
    int unsigned cnt, best, least, wt, idx, ticks;
    rsp_t rsp;
    cnt   = stacks_in_use();
    best  = 0;
    least = 32'hFFFF_FFFF;
    idx   = item.stack_index;
    rsp   = '0;
    rsp.status = ST_OK;
    case (item.req_type)
      REQ_ADD: begin
        // scan downward so ties land on the newest stack
        for (int i = int'(cnt) - 1; i >= 0; i--) begin
          wt = stack_weight(i);
          if (wt < least) begin
            least = wt;
            best  = i;
          end
        end
        if (least > cfg_thresh && cnt < NumStacks) begin
          best = cnt;
          aged_swaps[best] = '0;
          cur_swaps[best]  = '0;
          thread_cnt[best] = '0;
          active_tid[best] = '0;
          opened_stacks    = opened_stacks + 5'd1;
          cnt = stacks_in_use();
          rsp.stack_created = 1'b1;
        end
        if (thread_cnt[best] >= CountMax) rsp.status = ST_SATURATED;
        else thread_cnt[best] = thread_cnt[best] + 16'd1;
        rsp.chosen_stack = best[3:0];
      end
      REQ_REMOVE: begin
        if (idx >= cnt) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          if (active_tid[idx] == item.thread_id) active_tid[idx] = '0;
          if (thread_cnt[idx] == '0) rsp.status = ST_SATURATED;
          else thread_cnt[idx] = thread_cnt[idx] - 16'd1;
        end
      end
      REQ_PLACE: begin
        if (idx >= cnt) begin
          rsp.status = ST_BAD_INDEX;
        end else if (active_tid[idx] != item.thread_id) begin
          if (active_tid[idx] != '0) begin
            if (cur_swaps[idx] >= CountMax) rsp.status = ST_SATURATED;
            else cur_swaps[idx] = cur_swaps[idx] + 16'd1;
          end
          active_tid[idx] = item.thread_id;
        end
      end
      default: begin
        ticks = 32'(tick_cnt) + 1;
        if (ticks > cfg_period) begin
          tick_cnt = '0;
          for (int i = 0; i < int'(cnt); i++) begin
            aged_swaps[i] = 16'((32'(aged_swaps[i]) + 32'(cur_swaps[i])) / 2);
            cur_swaps[i]  = '0;
          end
        end else begin
          tick_cnt = ticks[15:0];
        end
      end
    endcase
    rsp.stack_count = cnt[4:0];
    return rsp;
  endfunction

  function automatic req_t make_req(req_e kind, int unsigned idx, int unsigned tid);
    req_t r;
    r.req_type    = kind;
    r.stack_index = idx[3:0];
    r.thread_id   = tid[15:0];
    return r;
  endfunction

  // Leave start high after acceptance; whoever waits next lowers it.
  task automatic send_item(input req_t item);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(predict_policy(item));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (addr)
      CFG_INIT_STACKS:  cfg_init   = data[4:0];
      CFG_AGING_PERIOD: cfg_period = data;
      CFG_SPAWN_THRESH: cfg_thresh = data;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, result_o);
        mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("chosen_stack", want.chosen_stack, result_o.chosen_stack);
        check_field("stack_created", want.stack_created, result_o.stack_created);
        check_field("stack_count", want.stack_count, result_o.stack_count);
        check_field("status", want.status, result_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    repeat (3) send_item(make_req(REQ_ADD, 0, 0));
    send_item(make_req(REQ_REMOVE, 15, 1));
    send_item(make_req(REQ_PLACE, 4, 1));
    send_item(make_req(REQ_TICK, 0, 0));
  endtask

  task automatic test_place_remove();
    send_item(make_req(REQ_PLACE, 0, 16'hFFFF));
    send_item(make_req(REQ_PLACE, 0, 16'hFFFF));  // already active: no swap
    send_item(make_req(REQ_PLACE, 0, 1));
    send_item(make_req(REQ_PLACE, 0, 0));         // swap, leaves no active thread
    send_item(make_req(REQ_PLACE, 0, 0));
    send_item(make_req(REQ_REMOVE, 0, 1));        // empty stack underflows
    send_item(make_req(REQ_PLACE, 3, 7));
    send_item(make_req(REQ_REMOVE, 3, 7));
    send_item(make_req(REQ_REMOVE, 3, 7));
  endtask

  task automatic test_count_clamp();
    write_reg(CFG_INIT_STACKS, 16'd0);
    send_item(make_req(REQ_TICK, 0, 0));
    write_reg(CFG_INIT_STACKS, 16'd3);
    send_item(make_req(REQ_TICK, 0, 0));
    write_reg(CFG_INIT_STACKS, 16'd17);
    send_item(make_req(REQ_PLACE, 15, 5));
    send_item(make_req(REQ_ADD, 0, 0));
    write_reg(CFG_INIT_STACKS, 16'd31);
    send_item(make_req(REQ_TICK, 0, 0));
    // upper data bits beyond the register width are dropped
    write_reg(CFG_INIT_STACKS, 16'hFFE5);
    send_item(make_req(REQ_REMOVE, 4, 9));
    send_item(make_req(REQ_PLACE, 15, 5));
    write_reg(CFG_INIT_STACKS, 16'd4);
  endtask

  task automatic test_aging();
    write_reg(CFG_AGING_PERIOD, 16'd0);
    send_item(make_req(REQ_PLACE, 1, 2));
    send_item(make_req(REQ_PLACE, 1, 3));
    send_item(make_req(REQ_PLACE, 1, 2));
    send_item(make_req(REQ_TICK, 0, 0));
    send_item(make_req(REQ_ADD, 0, 0));
    write_reg(CFG_AGING_PERIOD, 16'd1);
    repeat (3) send_item(make_req(REQ_TICK, 0, 0));
    write_reg(CFG_AGING_PERIOD, 16'hFFFF);
    send_item(make_req(REQ_TICK, 0, 0));
  endtask

  task automatic test_spawn();
    write_reg(CFG_SPAWN_THRESH, 16'd0);
    repeat (5) send_item(make_req(REQ_ADD, 0, 0));
    write_reg(CFG_SPAWN_THRESH, 16'hFFFF);
    send_item(make_req(REQ_ADD, 0, 0));
  endtask

  task automatic test_swap_burst();
    wait_idle();
    no_idle = 1'b1;
    // alternate two threads on one stack back to back to pile up swaps
    for (int n = 0; n < BurstItems; n++) send_item(make_req(REQ_PLACE, 0, (n % 2) + 1));
    no_idle = 1'b0;
    send_item(make_req(REQ_TICK, 0, 0));
    send_item(make_req(REQ_ADD, 0, 0));
  endtask

  task automatic test_random_traffic();
    int unsigned cnt;
    int          pick;
    logic [15:0] init_val, period_val, thresh_val;
    req_t        item;
    for (int p = 0; p < RandomPhases; p++) begin
      init_val = (p == 0) ? 16'd4 : (p == RandomPhases - 1) ? 16'd16
                                  : 16'($urandom_range(0, 31));
      case ($urandom_range(0, 3))
        0:       period_val = 16'd0;
        1:       period_val = 16'hFFFF;
        default: period_val = 16'($urandom_range(1, 12));
      endcase
      // keep the table small early on, then let it grow to full size
      thresh_val = (p == RandomPhases - 1) ? 16'd0
                 : (p < 2) ? 16'($urandom_range(200, 65535))
                 : 16'($urandom_range(0, 60));
      write_reg(CFG_INIT_STACKS, init_val);
      write_reg(CFG_AGING_PERIOD, period_val);
      write_reg(CFG_SPAWN_THRESH, thresh_val);
      for (int n = 0; n < RandomItems / RandomPhases; n++) begin
        cnt  = stacks_in_use();
        pick = $urandom_range(0, 99);
        item.req_type = (pick < 30) ? REQ_ADD : (pick < 55) ? REQ_PLACE
                      : (pick < 75) ? REQ_REMOVE : REQ_TICK;
        item.stack_index = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, cnt - 1))
                                                       : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 6)       item.thread_id = 16'($urandom_range(1, 6));
        else if (pick == 6) item.thread_id = 16'd0;
        else if (pick == 7) item.thread_id = 16'hFFFF;
        else                item.thread_id = 16'($urandom_range(0, 65535));
        send_item(item);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_place_remove();
    test_count_clamp();
    test_aging();
    test_spawn();
    test_swap_burst();
    test_random_traffic();
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
